// ===== sv/sorted_set_table_core_macros.svh =====
// Assertion macros shared by the checker of sorted_set_table_core.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SORTED_SET_TABLE_CORE_MACROS_SVH
`define SORTED_SET_TABLE_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SST_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sorted set table check failed");

// The consequent must hold in the cycle after the antecedent.
`define SST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sorted set table check failed");

`endif

// ===== sv/sst_pkg.sv =====
// Sorted set types: request modes, result codes, controller states, cell control, results.
// No dependencies.
`timescale 1ns / 1ps

package sst_pkg;

	typedef enum logic [1:0] {
		MODE_INSERT  = 2'd0,
		MODE_DELETE  = 2'd1,
		MODE_LOOKUP  = 2'd2,
		MODE_READOUT = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_PRESENT   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_DELETE,
		CELL_ROTATE
	} cell_op_t;

	typedef enum logic {
		S_IDLE,
		S_READOUT
	} ctrl_state_t;

	typedef struct packed {
		cell_op_t op;
		logic     occupied;
		logic     tail;
	} cell_ctl_t;

	typedef struct packed {
		status_t            status;
		logic               found;
		logic signed [31:0] element;
		logic [5:0]         stored_count;
		logic               last;
	} result_t;

endpackage

// ===== sv/sorted_set_table_core.sv =====
// Sorted set table top level: a chain of compare-and-shift cells, a small controller and the
// result queue. Depends on sst_pkg, sst_cell and sst_outq.
//
//   channel | valid     | stall     | fields
//   request | in_valid  | in_stall  | mode, value
//   result  | out_valid | out_stall | status, found, element, stored_count, last
//
// For insert, delete and lookup all cells compare against the operand at once and shift in
// the same edge, so a new request may follow every cycle unless in_stall is raised.
// A read-out of a nonempty table holds the request side while the occupied cells rotate
// once around, one element leaving the head cell per cycle while the queue is not full; a
// read-out of an empty table answers with a single marked result.
// Reset empties the table at once; cell contents are not cleared.
// A stalled result side fills the two-entry queue and then stalls requests and read-out.
`timescale 1ns / 1ps

module sorted_set_table_core #(
	parameter int CAPACITY = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               found,
	output logic signed [31:0] element,
	output logic [5:0]         stored_count,
	output logic               last
);
	import sst_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	ctrl_state_t        state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic [CW-1:0]      rd_cnt_q, rd_cnt_d;
	cell_op_t           cell_op;
	logic               push;
	result_t            res;
	result_t            out_data;
	logic               q_full;
	logic               accept;
	logic               present;
	logic               is_full;
	logic               rd_last;
	logic signed [31:0] ent [CAPACITY];
	logic [CAPACITY-1:0] lt;
	logic [CAPACITY-1:0] eq;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			cell_ctl_t ctl;
			logic               lt_prev;
			logic signed [31:0] left;
			logic signed [31:0] right;

			assign ctl.op = cell_op;
			assign ctl.occupied = (CW'(gi) < count_q);
			assign ctl.tail = (count_q == CW'(gi + 1));

			// The slot before the first one counts as below every operand.
			if (gi == 0) begin : g_first
				assign lt_prev = 1'b1;
				assign left = value;
			end else begin : g_inner
				assign lt_prev = lt[gi-1];
				assign left = ent[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_end
				assign right = ent[gi];
			end else begin : g_mid
				assign right = ent[gi+1];
			end

			sst_cell u_cell (
				.clk     (clk),
				.ctl     (ctl),
				.value   (value),
				.lt_prev (lt_prev),
				.left    (left),
				.right   (right),
				.head    (ent[0]),
				.entry   (ent[gi]),
				.lt      (lt[gi]),
				.eq      (eq[gi])
			);
		end
	endgenerate

	assign present = |eq;
	assign is_full = (count_q == CW'(CAPACITY));
	assign rd_last = ((rd_cnt_q + CW'(1)) == count_q);
	assign in_stall = (state_q != S_IDLE) || q_full;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rd_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rd_cnt_q <= rd_cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		rd_cnt_d = rd_cnt_q;
		cell_op = CELL_HOLD;
		push = 1'b0;
		res.status = ST_DONE;
		res.found = 1'b0;
		res.element = '0;
		res.last = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					push = 1'b1;
					case (mode_t'(mode))
						MODE_INSERT: begin
							if (present) begin
								res.status = ST_PRESENT;
								res.found = 1'b1;
							end else if (is_full) begin
								res.status = ST_FULL;
							end else begin
								cell_op = CELL_INSERT;
								count_d = count_q + CW'(1);
							end
						end
						MODE_DELETE: begin
							if (present) begin
								cell_op = CELL_DELETE;
								count_d = count_q - CW'(1);
								res.found = 1'b1;
							end else begin
								res.status = ST_NOT_FOUND;
							end
						end
						MODE_LOOKUP: begin
							res.found = present;
						end
						MODE_READOUT: begin
							// An empty table answers with a single marked result.
							if (count_q != '0) begin
								push = 1'b0;
								rd_cnt_d = '0;
								state_d = S_READOUT;
							end
						end
						default: begin
							push = 1'b0;
						end
					endcase
				end
			end
			S_READOUT: begin
				if (!q_full) begin
					push = 1'b1;
					cell_op = CELL_ROTATE;
					res.element = ent[0];
					res.last = rd_last;
					rd_cnt_d = rd_cnt_q + CW'(1);
					if (rd_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		res.stored_count = 6'(count_d);
	end

	sst_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.full      (q_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign status = out_data.status;
	assign found = out_data.found;
	assign element = out_data.element;
	assign stored_count = out_data.stored_count;
	assign last = out_data.last;

endmodule

// ===== sv/sst_cell.sv =====
// One slot of the sorted chain: holds a value, compares it with the request operand and
// takes its own, its neighbor's, the head's or the operand on a shift. Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_cell (
	input  logic               clk,
	input  sst_pkg::cell_ctl_t ctl,
	input  logic signed [31:0] value,
	input  logic               lt_prev,
	input  logic signed [31:0] left,
	input  logic signed [31:0] right,
	input  logic signed [31:0] head,
	output logic signed [31:0] entry,
	output logic               lt,
	output logic               eq
);
	import sst_pkg::*;

	logic signed [31:0] entry_q;

	assign entry = entry_q;
	assign lt = ctl.occupied && (entry_q < value);
	assign eq = ctl.occupied && (entry_q == value);

	// An insert opens a gap at the first slot not below the operand; a delete closes it.
	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (!lt) begin
					entry_q <= lt_prev ? value : left;
				end
			end
			CELL_DELETE: begin
				if (!lt) begin
					entry_q <= right;
				end
			end
			CELL_ROTATE: begin
				entry_q <= ctl.tail ? head : right;
			end
			default: begin
				entry_q <= entry_q;
			end
		endcase
	end

endmodule

// ===== sv/sst_outq.sv =====
// Two-entry result queue that separates the table from the output handshake.
// Depends on sst_pkg.
`timescale 1ns / 1ps

module sst_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sst_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output sst_pkg::result_t out_data
);
	import sst_pkg::*;

	result_t    data_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign full = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data = data_q[rd_ptr_q];
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/sst_checker.sv =====
// Port-level checks for sorted_set_table_core, attached by a bind statement.
// Depends on sst_pkg and sorted_set_table_core_macros.svh.
`timescale 1ns / 1ps
`include "sorted_set_table_core_macros.svh"

module sst_props #(
	parameter int CAPACITY = 32
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         status,
	input logic               found,
	input logic signed [31:0] element,
	input logic [5:0]         stored_count,
	input logic               last
);
	import sst_pkg::*;

	localparam logic [5:0] CapCount = 6'(CAPACITY);

	// A refused insert can only happen with every slot in use.
	`SST_ASSERT_SAME(a_full_count, out_valid && (status == ST_FULL), stored_count == CapCount)

	// Only read-out results carry an element, and those never report membership.
	`SST_ASSERT_SAME(a_found_single, out_valid && found, (element == '0) && last)

	// Once a read-out result leaves, the next one is ready at once and the count is unchanged.
	`SST_ASSERT_NEXT(a_readout_flow, out_valid && !out_stall && !last, out_valid && (status == ST_DONE) && (stored_count == $past(stored_count)))

	// A stalled result holds its element.
	`SST_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(element))

endmodule

bind sorted_set_table_core sst_props #(.CAPACITY(CAPACITY)) u_sst_props (.*);
